// ----- hdl/att_pkg.sv -----
// Shared types and constants of the ANSI text terminal.
// Holds the command set between parser and executor and the result layout.
// Depends on nothing; the top level, att_front and att_back use it.
package att_pkg;

  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_LBRKT = 8'h5B;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] FIN_H    = 8'h48;
  localparam logic [7:0] FIN_F    = 8'h66;
  localparam logic [7:0] FIN_J    = 8'h4A;
  localparam logic [7:0] FIN_K    = 8'h4B;
  localparam logic [7:0] FIN_A    = 8'h41;
  localparam logic [7:0] FIN_B    = 8'h42;
  localparam logic [7:0] FIN_C    = 8'h43;
  localparam logic [7:0] FIN_D    = 8'h44;
  localparam logic [7:0] FIN_M    = 8'h6D;

  localparam logic [9:0] PARAM_MAX   = 10'd1023;
  localparam logic [9:0] SGR_RESET   = 10'd0;
  localparam logic [9:0] SGR_REV_ON  = 10'd7;
  localparam logic [9:0] SGR_REV_OFF = 10'd27;
  localparam logic [9:0] SGR_FG_LO   = 10'd30;
  localparam logic [9:0] SGR_FG_HI   = 10'd37;
  localparam logic [9:0] SGR_BG_LO   = 10'd40;
  localparam logic [9:0] SGR_BG_HI   = 10'd47;
  localparam logic [9:0] SGR_FGB_LO  = 10'd90;
  localparam logic [9:0] SGR_FGB_HI  = 10'd97;
  localparam logic [9:0] SGR_BGB_LO  = 10'd100;
  localparam logic [9:0] SGR_BGB_HI  = 10'd107;
  localparam logic [9:0] ED_BELOW    = 10'd0;
  localparam logic [9:0] ED_ALL      = 10'd2;

  localparam logic [3:0] FG_DEFAULT = 4'd8;
  localparam logic [3:0] BG_DEFAULT = 4'd0;
  localparam logic [15:0] BLANK_CELL = {CH_SPACE, FG_DEFAULT, BG_DEFAULT};

  typedef enum logic [3:0] {
    OP_NOP, OP_READ, OP_CHAR, OP_CR, OP_LF, OP_BS, OP_TAB, OP_CUP,
    OP_UP, OP_DOWN, OP_RIGHT, OP_LEFT, OP_ED, OP_EL
  } op_t;

  typedef enum logic [1:0] {PM_NORMAL, PM_ESC, PM_CSI} pmode_t;
  typedef enum logic {F_IDLE, F_SGR} fstate_t;
  typedef enum logic [1:0] {B_WIPE, B_IDLE, B_READ, B_WRITE} bstate_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
    logic [9:0] arg0;
    logic [9:0] arg1;
    logic [4:0] rrow;
    logic [6:0] rcol;
  } cmd_t;

  typedef struct packed {
    logic [4:0] row;
    logic [6:0] col;
    logic [7:0] ch;
    logic [3:0] fg;
    logic [3:0] bg;
  } res_t;

endpackage

// ----- hdl/ansi_text_terminal.sv -----
// Top level of the ANSI text terminal: parser, command queue, executor and
// result queue. Depends on att_pkg, att_fifo, att_front and att_back.
//
// Items enter through push/full and results leave through empty/pop, one
// result per item in order. After reset the cell store is cleared one cell
// per cycle, and full stays high until it is clear. The executor takes one
// command per cycle while idle and the result queue has room; a cell read
// is answered through the registered store port in a further state. A line
// feed at the bottom row and a wrapping character that scrolls clear the new
// bottom row (the character is written after it), erase line clears the rest
// of the line and erase screen the whole store, one store write per cycle.
// An SGR sequence holds the parser while it applies its parameters in turn.
module ansi_text_terminal #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  parameter int MAX_PARAMS = 8
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic       req_type,
  input  logic [7:0] data_byte,
  input  logic [4:0] read_row,
  input  logic [6:0] read_col,
  output logic       empty,
  input  logic       pop,
  output logic [4:0] cursor_row,
  output logic [6:0] cursor_col,
  output logic [7:0] cell_char,
  output logic [3:0] cell_fg,
  output logic [3:0] cell_bg
);
  localparam int CMDW = $bits(att_pkg::cmd_t);
  localparam int RESW = $bits(att_pkg::res_t);

  logic front_ready, init, accept;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  logic res_push, out_full;
  att_pkg::cmd_t cmd_in;
  logic [CMDW-1:0] cmd_vec;
  att_pkg::res_t res_in;
  logic [RESW-1:0] res_vec;
  att_pkg::res_t res_out;

  assign full   = init || !front_ready;
  assign accept = push && !full;

  att_front #(.ROWS(ROWS), .COLS(COLS), .MAX_PARAMS(MAX_PARAMS)) u_front (
    .clk(clk), .rst(rst), .accept(accept), .req_type(req_type),
    .data_byte(data_byte), .read_row(read_row), .read_col(read_col),
    .cmd_full(cmd_full), .ready(front_ready), .cmd_push(cmd_push), .cmd(cmd_in)
  );

  att_fifo #(.WIDTH(CMDW), .DEPTH(2)) u_cmd_q (
    .clk(clk), .rst(rst), .wr(cmd_push), .wdata(cmd_in), .rd(cmd_pop),
    .rdata(cmd_vec), .full(cmd_full), .empty(cmd_empty)
  );

  att_back #(.ROWS(ROWS), .COLS(COLS)) u_back (
    .clk(clk), .rst(rst), .cmd_valid(!cmd_empty), .cmd(att_pkg::cmd_t'(cmd_vec)),
    .out_ready(!out_full), .cmd_pop(cmd_pop), .res_push(res_push), .res(res_in),
    .init(init)
  );

  att_fifo #(.WIDTH(RESW), .DEPTH(2)) u_res_q (
    .clk(clk), .rst(rst), .wr(res_push), .wdata(res_in), .rd(pop),
    .rdata(res_vec), .full(out_full), .empty(empty)
  );

  assign res_out    = att_pkg::res_t'(res_vec);
  assign cursor_row = res_out.row;
  assign cursor_col = res_out.col;
  assign cell_char  = res_out.ch;
  assign cell_fg    = res_out.fg;
  assign cell_bg    = res_out.bg;
endmodule

// ----- hdl/att_fifo.sv -----
// Small first-in first-out queue of plain words.
// Used for the command queue and the result queue; no package needed.
module att_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] store [DEPTH];
  logic [PW-1:0] wptr, rptr;
  logic [NW-1:0] count;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = store[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      store[wptr] <= wdata;
    end
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd && !empty) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      count <= count + NW'(wr && !full) - NW'(rd && !empty);
    end
  end
endmodule

// ----- hdl/att_front.sv -----
// Front part: escape sequence parser, parameter list and current colors.
// Turns each accepted item into one command; depends on att_pkg.
module att_front #(
  parameter int ROWS = 25,
  parameter int COLS = 80,
  parameter int MAX_PARAMS = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  logic            req_type,
  input  logic [7:0]      data_byte,
  input  logic [4:0]      read_row,
  input  logic [6:0]      read_col,
  input  logic            cmd_full,
  output logic            ready,
  output logic            cmd_push,
  output att_pkg::cmd_t   cmd
);
  localparam int LN  = (MAX_PARAMS < 2) ? 2 : MAX_PARAMS;
  localparam int IW  = $clog2(LN);
  localparam int CNW = $clog2(MAX_PARAMS + 1);

  att_pkg::fstate_t fstate, fstate_next;
  att_pkg::pmode_t  pmode, pmode_next;
  logic [9:0]     plist [LN];
  logic [CNW-1:0] pcount, pcount_next;
  logic [9:0]     paccum, paccum_next;
  logic [3:0]     fg, fg_next, bg, bg_next;
  logic           rev, rev_next;
  logic [CNW-1:0] sidx, sidx_next;

  logic           pl_clear, pl_we;
  logic [9:0]     eff0, eff1, sgr_p;
  logic           room;
  logic [CNW-1:0] cnt_pushed;
  logic [13:0]    acc_sum;

  assign ready = (fstate == att_pkg::F_IDLE) && !cmd_full;
  assign room  = pcount < CNW'(MAX_PARAMS);
  assign cnt_pushed = room ? pcount + 1'b1 : pcount;
  assign eff0 = (pcount == '0) ? paccum : plist[0];
  assign eff1 = ((pcount == CNW'(1)) && (MAX_PARAMS > 1)) ? paccum : plist[1];
  assign acc_sum = {paccum, 3'b000} + {3'b000, paccum, 1'b0} + 14'(data_byte[3:0]);
  assign sgr_p = plist[IW'(sidx)];

  always_ff @(posedge clk) begin
    if (rst || pl_clear) begin
      for (int i = 0; i < LN; i++) begin
        plist[i] <= '0;
      end
    end else if (pl_we) begin
      plist[IW'(pcount)] <= paccum;
    end
    if (rst) begin
      fstate <= att_pkg::F_IDLE;
      pmode  <= att_pkg::PM_NORMAL;
      pcount <= '0;
      paccum <= '0;
      fg     <= att_pkg::FG_DEFAULT;
      bg     <= att_pkg::BG_DEFAULT;
      rev    <= 1'b0;
      sidx   <= '0;
    end else begin
      fstate <= fstate_next;
      pmode  <= pmode_next;
      pcount <= pcount_next;
      paccum <= paccum_next;
      fg     <= fg_next;
      bg     <= bg_next;
      rev    <= rev_next;
      sidx   <= sidx_next;
    end
  end

  always_comb begin
    fstate_next = fstate;
    pmode_next  = pmode;
    pcount_next = pcount;
    paccum_next = paccum;
    fg_next     = fg;
    bg_next     = bg;
    rev_next    = rev;
    sidx_next   = sidx;
    pl_clear    = 1'b0;
    pl_we       = 1'b0;
    cmd_push    = 1'b0;
    cmd         = '0;
    cmd.op      = att_pkg::OP_NOP;
    unique case (fstate)
      att_pkg::F_IDLE: begin
        if (accept) begin
          cmd_push = 1'b1;
          if (req_type) begin
            if ((32'(read_row) < ROWS) && (32'(read_col) < COLS)) begin
              cmd.op   = att_pkg::OP_READ;
              cmd.rrow = read_row;
              cmd.rcol = read_col;
            end
          end else begin
            unique case (pmode)
              att_pkg::PM_NORMAL: begin
                unique case (data_byte)
                  att_pkg::CH_ESC: pmode_next = att_pkg::PM_ESC;
                  att_pkg::CH_CR:  cmd.op = att_pkg::OP_CR;
                  att_pkg::CH_LF:  cmd.op = att_pkg::OP_LF;
                  att_pkg::CH_BS:  cmd.op = att_pkg::OP_BS;
                  att_pkg::CH_TAB: cmd.op = att_pkg::OP_TAB;
                  default: begin
                    cmd.op = att_pkg::OP_CHAR;
                    cmd.ch = data_byte;
                    cmd.fg = rev ? bg : fg;
                    cmd.bg = rev ? fg : bg;
                  end
                endcase
              end
              att_pkg::PM_ESC: begin
                if (data_byte == att_pkg::CH_LBRKT) begin
                  pmode_next  = att_pkg::PM_CSI;
                  pcount_next = '0;
                  paccum_next = '0;
                  pl_clear    = 1'b1;
                end else begin
                  pmode_next = att_pkg::PM_NORMAL;
                end
              end
              att_pkg::PM_CSI: begin
                if ((data_byte >= att_pkg::CH_ZERO) && (data_byte <= att_pkg::CH_NINE)) begin
                  paccum_next = (acc_sum > 14'(att_pkg::PARAM_MAX)) ?
                                att_pkg::PARAM_MAX : acc_sum[9:0];
                end else if (data_byte == att_pkg::CH_SEMI) begin
                  pl_we       = room;
                  pcount_next = cnt_pushed;
                  paccum_next = '0;
                end else begin
                  pl_we       = room;
                  pcount_next = cnt_pushed;
                  pmode_next  = att_pkg::PM_NORMAL;
                  cmd.arg0    = eff0;
                  cmd.arg1    = eff1;
                  unique case (data_byte)
                    att_pkg::FIN_H, att_pkg::FIN_F: cmd.op = att_pkg::OP_CUP;
                    att_pkg::FIN_J: begin
                      if ((eff0 == att_pkg::ED_BELOW) || (eff0 == att_pkg::ED_ALL)) begin
                        cmd.op = att_pkg::OP_ED;
                      end
                    end
                    att_pkg::FIN_K: cmd.op = att_pkg::OP_EL;
                    att_pkg::FIN_A: cmd.op = att_pkg::OP_UP;
                    att_pkg::FIN_B: cmd.op = att_pkg::OP_DOWN;
                    att_pkg::FIN_C: cmd.op = att_pkg::OP_RIGHT;
                    att_pkg::FIN_D: cmd.op = att_pkg::OP_LEFT;
                    att_pkg::FIN_M: begin
                      cmd_push    = 1'b0;
                      sidx_next   = '0;
                      fstate_next = att_pkg::F_SGR;
                    end
                    default: cmd.op = att_pkg::OP_NOP;
                  endcase
                end
              end
              default: pmode_next = att_pkg::PM_NORMAL;
            endcase
          end
        end
      end
      att_pkg::F_SGR: begin
        if (sidx < pcount) begin
          sidx_next = sidx + 1'b1;
          case (sgr_p) inside
            att_pkg::SGR_RESET: begin
              fg_next  = att_pkg::FG_DEFAULT;
              bg_next  = att_pkg::BG_DEFAULT;
              rev_next = 1'b0;
            end
            att_pkg::SGR_REV_ON:  rev_next = 1'b1;
            att_pkg::SGR_REV_OFF: rev_next = 1'b0;
            [att_pkg::SGR_FG_LO:att_pkg::SGR_FG_HI]:
              fg_next = 4'(sgr_p - att_pkg::SGR_FG_LO);
            [att_pkg::SGR_BG_LO:att_pkg::SGR_BG_HI]:
              bg_next = 4'(sgr_p - att_pkg::SGR_BG_LO);
            [att_pkg::SGR_FGB_LO:att_pkg::SGR_FGB_HI]:
              fg_next = 4'(sgr_p - att_pkg::SGR_FGB_LO);
            [att_pkg::SGR_BGB_LO:att_pkg::SGR_BGB_HI]:
              bg_next = 4'(sgr_p - att_pkg::SGR_BGB_LO);
            default: ;
          endcase
        end else if (!cmd_full) begin
          cmd_push    = 1'b1;
          fstate_next = att_pkg::F_IDLE;
        end
      end
      default: fstate_next = att_pkg::F_IDLE;
    endcase
  end
endmodule

// ----- hdl/att_back.sv -----
// Back part: cursor, scroll offset and the cell store, which it clears,
// writes and reads. Executes one command at a time; depends on att_pkg.
module att_back #(
  parameter int ROWS = 25,
  parameter int COLS = 80
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  att_pkg::cmd_t cmd,
  input  logic          out_ready,
  output logic          cmd_pop,
  output logic          res_push,
  output att_pkg::res_t res,
  output logic          init
);
  localparam int RW    = $clog2(ROWS);
  localparam int CW    = $clog2(COLS);
  localparam int CCW   = $clog2(COLS + 1);
  localparam int DEPTH = ROWS * COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [RW-1:0]  ROW_LAST = RW'(ROWS - 1);
  localparam logic [CCW-1:0] COL_LAST = CCW'(COLS - 1);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_data;

  att_pkg::bstate_t state, state_next;
  logic [RW-1:0]  top, top_next, crow, crow_next;
  logic [CCW-1:0] ccol, ccol_next;
  logic [AW-1:0]  clr_addr, clr_addr_next, clr_end, clr_end_next;
  logic           pend_write, pend_write_next, res_pend, res_pend_next, init_next;
  logic [15:0]    wcell, wcell_next;

  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [15:0]    mem_wdata;
  logic [RW-1:0]  av_row, prow, top_inc, lf_row;
  logic [CW-1:0]  av_col;
  logic [RW:0]    psum;
  logic [AW-1:0]  calc_addr, scroll_base;
  logic           lf_scroll;
  logic [9:0]     n, r1, c1;
  logic [10:0]    row_sum, col_sum;
  logic [CCW:0]   tab_col;
  logic [15:0]    cell_out;

  always_comb begin
    if (state == att_pkg::B_IDLE && cmd.op == att_pkg::OP_READ) begin
      av_row = RW'(cmd.rrow);
      av_col = CW'(cmd.rcol);
    end else begin
      av_row = crow;
      av_col = CW'(ccol);
    end
  end

  assign psum        = {1'b0, top} + {1'b0, av_row};
  assign prow        = (psum >= (RW+1)'(ROWS)) ? RW'(psum - (RW+1)'(ROWS)) : RW'(psum);
  assign calc_addr   = AW'(prow * COLS) + AW'(av_col);
  assign scroll_base = AW'(top * COLS);
  assign top_inc     = (top == ROW_LAST) ? '0 : top + 1'b1;
  assign lf_scroll   = (crow == ROW_LAST);
  assign lf_row      = lf_scroll ? crow : crow + 1'b1;
  assign n           = (cmd.arg0 == '0) ? 10'd1 : cmd.arg0;
  assign r1          = (cmd.arg0 == '0) ? 10'd0 : cmd.arg0 - 1'b1;
  assign c1          = (cmd.arg1 == '0) ? 10'd0 : cmd.arg1 - 1'b1;
  assign row_sum     = 11'(crow) + 11'(n);
  assign col_sum     = 11'(ccol) + 11'(n);
  assign tab_col     = ({1'b0, ccol} & ~(CCW+1)'(7)) + (CCW+1)'(8);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[calc_addr];
    wcell   <= wcell_next;
    if (rst) begin
      state      <= att_pkg::B_WIPE;
      top        <= '0;
      crow       <= '0;
      ccol       <= '0;
      clr_addr   <= '0;
      clr_end    <= AW'(DEPTH - 1);
      pend_write <= 1'b0;
      res_pend   <= 1'b0;
      init       <= 1'b1;
    end else begin
      state      <= state_next;
      top        <= top_next;
      crow       <= crow_next;
      ccol       <= ccol_next;
      clr_addr   <= clr_addr_next;
      clr_end    <= clr_end_next;
      pend_write <= pend_write_next;
      res_pend   <= res_pend_next;
      init       <= init_next;
    end
  end

  always_comb begin
    state_next      = state;
    top_next        = top;
    crow_next       = crow;
    ccol_next       = ccol;
    clr_addr_next   = clr_addr;
    clr_end_next    = clr_end;
    pend_write_next = pend_write;
    res_pend_next   = res_pend;
    init_next       = init;
    wcell_next      = wcell;
    mem_we          = 1'b0;
    mem_waddr       = calc_addr;
    mem_wdata       = wcell;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    cell_out        = '0;
    unique case (state)
      att_pkg::B_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = att_pkg::BLANK_CELL;
        if (clr_addr == clr_end) begin
          init_next     = 1'b0;
          res_pend_next = 1'b0;
          if (pend_write) begin
            state_next = att_pkg::B_WRITE;
          end else begin
            res_push   = res_pend;
            state_next = att_pkg::B_IDLE;
          end
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end
      att_pkg::B_IDLE: begin
        if (cmd_valid && out_ready) begin
          cmd_pop  = 1'b1;
          res_push = 1'b1;
          unique case (cmd.op)
            att_pkg::OP_NOP: ;
            att_pkg::OP_READ: begin
              res_push   = 1'b0;
              state_next = att_pkg::B_READ;
            end
            att_pkg::OP_CHAR: begin
              wcell_next = {cmd.ch, cmd.fg, cmd.bg};
              if (ccol >= CCW'(COLS)) begin
                res_push  = 1'b0;
                ccol_next = '0;
                crow_next = lf_row;
                if (lf_scroll) begin
                  top_next        = top_inc;
                  clr_addr_next   = scroll_base;
                  clr_end_next    = scroll_base + AW'(COLS - 1);
                  pend_write_next = 1'b1;
                  res_pend_next   = 1'b1;
                  state_next      = att_pkg::B_WIPE;
                end else begin
                  state_next = att_pkg::B_WRITE;
                end
              end else begin
                mem_we    = 1'b1;
                mem_wdata = {cmd.ch, cmd.fg, cmd.bg};
                ccol_next = ccol + 1'b1;
              end
            end
            att_pkg::OP_CR: ccol_next = '0;
            att_pkg::OP_LF, att_pkg::OP_TAB: begin
              if (cmd.op == att_pkg::OP_TAB && tab_col < (CCW+1)'(COLS)) begin
                ccol_next = CCW'(tab_col);
              end else begin
                ccol_next = '0;
                crow_next = lf_row;
                if (lf_scroll) begin
                  res_push      = 1'b0;
                  top_next      = top_inc;
                  clr_addr_next = scroll_base;
                  clr_end_next  = scroll_base + AW'(COLS - 1);
                  res_pend_next = 1'b1;
                  state_next    = att_pkg::B_WIPE;
                end
              end
            end
            att_pkg::OP_BS: begin
              if (ccol != '0) begin
                ccol_next = ccol - 1'b1;
              end
            end
            att_pkg::OP_CUP: begin
              crow_next = (r1 >= 10'(ROWS)) ? ROW_LAST : RW'(r1);
              ccol_next = (c1 >= 10'(COLS)) ? COL_LAST : CCW'(c1);
            end
            att_pkg::OP_UP:
              crow_next = (n > 10'(crow)) ? '0 : crow - RW'(n);
            att_pkg::OP_DOWN:
              crow_next = (row_sum > 11'(ROWS - 1)) ? ROW_LAST : RW'(row_sum);
            att_pkg::OP_RIGHT:
              ccol_next = (col_sum > 11'(COLS - 1)) ? COL_LAST : CCW'(col_sum);
            att_pkg::OP_LEFT:
              ccol_next = (n > 10'(ccol)) ? '0 : ccol - CCW'(n);
            att_pkg::OP_ED: begin
              res_push      = 1'b0;
              top_next      = '0;
              crow_next     = '0;
              ccol_next     = '0;
              clr_addr_next = '0;
              clr_end_next  = AW'(DEPTH - 1);
              res_pend_next = 1'b1;
              state_next    = att_pkg::B_WIPE;
            end
            att_pkg::OP_EL: begin
              if (ccol < CCW'(COLS)) begin
                res_push      = 1'b0;
                clr_addr_next = calc_addr;
                clr_end_next  = calc_addr + AW'(COL_LAST - ccol);
                res_pend_next = 1'b1;
                state_next    = att_pkg::B_WIPE;
              end
            end
            default: ;
          endcase
        end
      end
      att_pkg::B_READ: begin
        res_push   = 1'b1;
        cell_out   = rd_data;
        state_next = att_pkg::B_IDLE;
      end
      att_pkg::B_WRITE: begin
        mem_we          = 1'b1;
        ccol_next       = ccol + 1'b1;
        pend_write_next = 1'b0;
        res_push        = 1'b1;
        state_next      = att_pkg::B_IDLE;
      end
      default: state_next = att_pkg::B_IDLE;
    endcase
    res.row = 5'(crow_next);
    res.col = 7'(ccol_next);
    res.ch  = cell_out[15:8];
    res.fg  = cell_out[7:4];
    res.bg  = cell_out[3:0];
  end
endmodule
